FILE: hw/rtl/pinhole_ray_generator_assert.svh
// assertion macros for the pinhole ray generator checker
// expects clk and rst_n in the scope of use
`ifndef PINHOLE_RAY_GENERATOR_ASSERT_SVH
`define PINHOLE_RAY_GENERATOR_ASSERT_SVH

// same-cycle implication
`define PRG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PRG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/prg_pkg.sv
// shared constants and register codes for the pinhole ray generator
// no dependencies
`default_nettype none

package prg_pkg;

    localparam int MAX_RESOLUTION_DEF = 4096;
    localparam int COORD_BITS_DEF     = 20;
    localparam int DIR_BITS_DEF       = 16;
    localparam int NORM_TOP           = 29;
    localparam int TAN_BITS           = 16;
    localparam int RES_REG_BITS       = 13;
    localparam int PIX_BITS           = 12;
    localparam int COORD_ONE          = 1024;

    typedef enum logic [2:0] {
        REG_EYE,
        REG_FOCAL,
        REG_UP,
        REG_TAN,
        REG_WIDTH,
        REG_HEIGHT
    } cfg_reg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/prg_norm.sv
// pipelined vector normaliser: magnitude, leading one search, common shift, squares,
// square root, per-lane restoring divide, sign restore; uses prg_pkg
`default_nettype none

module prg_norm #(
    parameter int IW   = 64,
    parameter int FRAC = 14,
    parameter int PW   = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [IW-1:0]   in_vec [3],
    input  logic [PW-1:0]          in_pay,
    output logic                   out_valid,
    output logic                   out_zero,
    output logic signed [FRAC+1:0] out_vec [3],
    output logic [PW-1:0]          out_pay
);
    import prg_pkg::*;

    localparam int MW = NORM_TOP + 1;
    localparam int SW = 2 * MW + 2;
    localparam int RW = MW + 1;
    localparam int QW = FRAC + 1;
    localparam int NW = MW + FRAC + 1;
    localparam int LW = $clog2(IW);

    typedef struct packed {
        logic          v;
        logic          zero;
        logic [2:0]    neg;
        logic [PW-1:0] pay;
    } side_t;

    // magnitude stage
    side_t          a_reg;
    logic [IW-1:0]  a_mag_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
        end
        else if (en)
        begin
            a_reg.v    <= in_valid;
            a_reg.zero <= 1'b0;
            a_reg.pay  <= in_pay;
            for (int i = 0; i < 3; i++)
            begin
                a_reg.neg[i] <= in_vec[i][IW-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_mag_reg[i] <= in_vec[i][IW-1] ? IW'(-in_vec[i]) : IW'(in_vec[i]);
            end
        end
    end

    // leading one search
    logic [IW-1:0]  top_or;
    logic [LW-1:0]  b_pos_next;
    side_t          b_reg;
    logic [LW-1:0]  b_pos_reg;
    logic [IW-1:0]  b_mag_reg [3];

    assign top_or = a_mag_reg[0] | a_mag_reg[1] | a_mag_reg[2];

    always_comb
    begin
        b_pos_next = '0;
        for (int j = 0; j < IW; j++)
        begin
            if (top_or[j])
            begin
                b_pos_next = LW'(j);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= '0;
        end
        else if (en)
        begin
            b_reg <= '{v: a_reg.v, zero: (top_or == '0), neg: a_reg.neg, pay: a_reg.pay};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_pos_reg <= b_pos_next;
            b_mag_reg <= a_mag_reg;
        end
    end

    // common shift into [2^29, 2^30)
    side_t          c_reg;
    logic [MW-1:0]  c_sh_next [3];
    logic [MW-1:0]  c_sh_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (int'(b_pos_reg) > NORM_TOP)
            begin
                c_sh_next[i] = MW'(b_mag_reg[i] >> (int'(b_pos_reg) - NORM_TOP));
            end
            else
            begin
                c_sh_next[i] = MW'(b_mag_reg[i]) << (NORM_TOP - int'(b_pos_reg));
            end
        end
    end

    // squares and sum
    side_t            d_reg;
    logic [MW-1:0]    d_sh_reg [3];
    logic [2*MW-1:0]  d_sq_reg [3];
    side_t            e_reg;
    logic [MW-1:0]    e_sh_reg [3];
    logic [SW-1:0]    e_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg <= '0;
            d_reg <= '0;
            e_reg <= '0;
        end
        else if (en)
        begin
            c_reg <= b_reg;
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_sh_reg  <= c_sh_next;
            d_sh_reg  <= c_sh_reg;
            e_sh_reg  <= d_sh_reg;
            for (int i = 0; i < 3; i++)
            begin
                d_sq_reg[i] <= (2*MW)'(c_sh_reg[i]) * (2*MW)'(c_sh_reg[i]);
            end
            e_sum_reg <= SW'(d_sq_reg[0]) + SW'(d_sq_reg[1]) + SW'(d_sq_reg[2]);
        end
    end

    // square root, one result bit per stage
    side_t          sqi_side [RW+1];
    logic [SW-1:0]  sqi_rem  [RW+1];
    logic [RW-1:0]  sqi_root [RW+1];
    logic [MW-1:0]  sqi_mag  [RW+1][3];
    side_t          sq_side_reg [RW];
    logic [SW-1:0]  sq_rem_reg  [RW];
    logic [RW-1:0]  sq_root_reg [RW];
    logic [MW-1:0]  sq_mag_reg  [RW][3];

    always_comb
    begin
        sqi_side[0] = e_reg;
        sqi_rem[0]  = e_sum_reg;
        sqi_root[0] = '0;
        sqi_mag[0]  = e_sh_reg;
        for (int s = 0; s < RW; s++)
        begin
            sqi_side[s+1] = sq_side_reg[s];
            sqi_rem[s+1]  = sq_rem_reg[s];
            sqi_root[s+1] = sq_root_reg[s];
            sqi_mag[s+1]  = sq_mag_reg[s];
        end
    end

    for (genvar s = 0; s < RW; s++)
    begin : g_sqrt
        localparam int K = RW - 1 - s;
        logic [SW:0] trial;
        logic        ge;

        assign trial = ((SW+1)'(sqi_root[s]) << (K + 1)) + ((SW+1)'(1) << (2 * K));
        assign ge    = {1'b0, sqi_rem[s]} >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_side_reg[s] <= '0;
            end
            else if (en)
            begin
                sq_side_reg[s] <= sqi_side[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rem_reg[s]  <= ge ? SW'({1'b0, sqi_rem[s]} - trial) : sqi_rem[s];
                sq_root_reg[s] <= ge ? (sqi_root[s] | (RW'(1) << K)) : sqi_root[s];
                sq_mag_reg[s]  <= sqi_mag[s];
            end
        end
    end

    // dividend set-up with half-length rounding
    side_t          f_reg;
    logic [NW-1:0]  f_rem_reg [3];
    logic [RW-1:0]  f_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_reg <= '0;
        end
        else if (en)
        begin
            f_reg <= sqi_side[RW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_len_reg <= sqi_root[RW];
            for (int i = 0; i < 3; i++)
            begin
                f_rem_reg[i] <= (NW'(sqi_mag[RW][i]) << FRAC) + NW'(sqi_root[RW] >> 1);
            end
        end
    end

    // restoring divide, one quotient bit per stage on all lanes
    side_t          dvi_side [QW+1];
    logic [NW-1:0]  dvi_rem  [QW+1][3];
    logic [QW-1:0]  dvi_q    [QW+1][3];
    logic [RW-1:0]  dvi_len  [QW+1];
    side_t          dv_side_reg [QW];
    logic [NW-1:0]  dv_rem_reg  [QW][3];
    logic [QW-1:0]  dv_q_reg    [QW][3];
    logic [RW-1:0]  dv_len_reg  [QW];

    always_comb
    begin
        dvi_side[0] = f_reg;
        dvi_rem[0]  = f_rem_reg;
        dvi_len[0]  = f_len_reg;
        for (int i = 0; i < 3; i++)
        begin
            dvi_q[0][i] = '0;
        end
        for (int t = 0; t < QW; t++)
        begin
            dvi_side[t+1] = dv_side_reg[t];
            dvi_rem[t+1]  = dv_rem_reg[t];
            dvi_q[t+1]    = dv_q_reg[t];
            dvi_len[t+1]  = dv_len_reg[t];
        end
    end

    for (genvar t = 0; t < QW; t++)
    begin : g_div
        localparam int K = QW - 1 - t;
        logic [NW:0] dsh;

        assign dsh = (NW+1)'(dvi_len[t]) << K;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_side_reg[t] <= '0;
            end
            else if (en)
            begin
                dv_side_reg[t] <= dvi_side[t];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_len_reg[t] <= dvi_len[t];
                for (int i = 0; i < 3; i++)
                begin
                    if ({1'b0, dvi_rem[t][i]} >= dsh)
                    begin
                        dv_rem_reg[t][i] <= NW'({1'b0, dvi_rem[t][i]} - dsh);
                        dv_q_reg[t][i]   <= dvi_q[t][i] | (QW'(1) << K);
                    end
                    else
                    begin
                        dv_rem_reg[t][i] <= dvi_rem[t][i];
                        dv_q_reg[t][i]   <= dvi_q[t][i];
                    end
                end
            end
        end
    end

    // sign restore
    side_t                 o_reg;
    logic signed [FRAC+1:0] o_vec_reg [3];
    logic signed [FRAC+1:0] q_s [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_s[i] = $signed({1'b0, dvi_q[QW][i]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_reg <= '0;
        end
        else if (en)
        begin
            o_reg <= dvi_side[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (dvi_side[QW].zero)
                begin
                    o_vec_reg[i] <= '0;
                end
                else
                begin
                    o_vec_reg[i] <= dvi_side[QW].neg[i] ? -q_s[i] : q_s[i];
                end
            end
        end
    end

    assign out_valid = o_reg.v;
    assign out_zero  = o_reg.zero;
    assign out_pay   = o_reg.pay;
    assign out_vec   = o_vec_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/pinhole_ray_generator.sv
// Pinhole camera primary ray generator. One pixel request is taken every cycle
// while the output is not stalled, and results leave in the same order after
// passing through an input stage, the forward normaliser, five stages of
// products for the right vector and the screen offset, the direction
// normaliser and an output register. Each normaliser runs a 31-stage square
// root and a (DIR_BITS-1)-stage divide. A stall on the output side freezes the
// whole pipeline; s_tready is low only while a finished ray waits. The ray
// origin is the eye position register. Configuration writes are taken at any
// time and must only be made while no pixel is in flight.
`default_nettype none

module pinhole_ray_generator #(
    parameter int MAX_RESOLUTION = prg_pkg::MAX_RESOLUTION_DEF,
    parameter int COORD_BITS     = prg_pkg::COORD_BITS_DEF,
    parameter int DIR_BITS       = prg_pkg::DIR_BITS_DEF,
    localparam int CFG_W = (COORD_BITS > DIR_BITS) ? 3 * COORD_BITS : 3 * DIR_BITS,
    localparam int TW    = ((3 * COORD_BITS + 3 * DIR_BITS + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,   // pixel_x, pixel_y
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [TW-1:0]    m_tdata,   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    output logic             m_tuser,   // degenerate
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);
    import prg_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int DB   = DIR_BITS;
    localparam int F    = DB - 2;
    localparam int RB   = $clog2(MAX_RESOLUTION) + 1;
    localparam int KW   = ((RB > PIX_BITS + 1) ? RB : PIX_BITS + 1) + 1;
    localparam int TSW  = TAN_BITS + 1;
    localparam int FHW  = DB + RB + 1;
    localparam int UTW  = DB + TSW;
    localparam int UKW  = UTW + KW;
    localparam int RTW  = 2 * DB + 1;
    localparam int RTTW = RTW + TSW;
    localparam int RKW  = RTTW + KW;
    localparam int W1   = FHW + 2 * F;
    localparam int W2   = RKW;
    localparam int W3   = UKW + F;
    localparam int WM   = (W1 > W2) ? ((W1 > W3) ? W1 : W3) : ((W2 > W3) ? W2 : W3);
    localparam int WW   = WM + 2;

    // configuration registers
    logic [3*CB-1:0]         eye_reg;
    logic [3*CB-1:0]         focal_reg;
    logic [3*DB-1:0]         up_reg;
    logic [TAN_BITS-1:0]     tan_reg;
    logic [RES_REG_BITS-1:0] width_reg;
    logic [RES_REG_BITS-1:0] height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_reg    <= '0;
            focal_reg  <= (3*CB)'(COORD_ONE);
            up_reg     <= (3*DB)'(1) << (2 * DB + F);
            tan_reg    <= TAN_BITS'(1) << (TAN_BITS - 2);
            width_reg  <= RES_REG_BITS'(1024);
            height_reg <= RES_REG_BITS'(768);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_EYE:    eye_reg    <= cfg_data[3*CB-1:0];
                REG_FOCAL:  focal_reg  <= cfg_data[3*CB-1:0];
                REG_UP:     up_reg     <= cfg_data[3*DB-1:0];
                REG_TAN:    tan_reg    <= cfg_data[TAN_BITS-1:0];
                REG_WIDTH:  width_reg  <= cfg_data[RES_REG_BITS-1:0];
                REG_HEIGHT: height_reg <= cfg_data[RES_REG_BITS-1:0];
                default:    ;
            endcase
        end
    end

    function automatic logic [RB-1:0] clamp_res(input logic [RES_REG_BITS-1:0] r);
        logic [RB-1:0] v;
        if (r == '0)
        begin
            v = RB'(1);
        end
        else if (int'(r) > MAX_RESOLUTION)
        begin
            v = RB'(MAX_RESOLUTION);
        end
        else
        begin
            v = RB'(r);
        end
        return v;
    endfunction

    logic [RB-1:0]           wr;
    logic [RB-1:0]           hr;
    logic signed [RB:0]      hr_s;
    logic signed [TSW-1:0]   tan_s;
    logic signed [DB-1:0]    up_c [3];

    assign wr    = clamp_res(width_reg);
    assign hr    = clamp_res(height_reg);
    assign hr_s  = $signed({1'b0, hr});
    assign tan_s = $signed({1'b0, tan_reg});

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            up_c[i] = $signed(up_reg[i*DB +: DB]);
        end
    end

    // global advance
    logic en;
    logic m_valid_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // input stage: eye to focal point, pixel offsets
    logic                 s0_v_reg;
    logic signed [CB:0]   s0_d_reg [3];
    logic signed [KW-1:0] s0_kx_reg;
    logic signed [KW-1:0] s0_ky_reg;
    logic [PIX_BITS-1:0]  pixel_x;
    logic [PIX_BITS-1:0]  pixel_y;

    assign pixel_x = s_tdata[PIX_BITS-1:0];
    assign pixel_y = s_tdata[2*PIX_BITS-1:PIX_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s0_d_reg[i] <= (CB+1)'($signed(focal_reg[i*CB +: CB]))
                             - (CB+1)'($signed(eye_reg[i*CB +: CB]));
            end
            s0_kx_reg <= $signed(KW'({pixel_x, 1'b0})) - $signed(KW'(wr));
            s0_ky_reg <= $signed(KW'({pixel_y, 1'b0})) - $signed(KW'(hr));
        end
    end

    // forward normaliser
    logic                 n1_v;
    logic                 n1_zero;
    logic signed [DB-1:0] fw [3];
    logic [2*KW-1:0]      n1_pay;

    prg_norm #(
        .IW   (CB + 1),
        .FRAC (F),
        .PW   (2 * KW)
    ) u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s0_v_reg),
        .in_vec    (s0_d_reg),
        .in_pay    ({s0_ky_reg, s0_kx_reg}),
        .out_valid (n1_v),
        .out_zero  (n1_zero),
        .out_vec   (fw),
        .out_pay   (n1_pay)
    );

    // right vector and screen offset products
    typedef struct packed {
        logic v;
        logic zero;
    } ctl_t;

    ctl_t                   p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [2*DB-1:0] p1_a_reg [3];
    logic signed [2*DB-1:0] p1_b_reg [3];
    logic signed [FHW-1:0]  p1_fh_reg [3];
    logic signed [UTW-1:0]  p1_ut_reg [3];
    logic signed [KW-1:0]   p1_kx_reg, p1_ky_reg;
    logic signed [RTW-1:0]  p2_rt_reg [3];
    logic signed [FHW-1:0]  p2_fh_reg [3];
    logic signed [UKW-1:0]  p2_uk_reg [3];
    logic signed [KW-1:0]   p2_kx_reg;
    logic signed [RTTW-1:0] p3_rtt_reg [3];
    logic signed [FHW-1:0]  p3_fh_reg [3];
    logic signed [UKW-1:0]  p3_uk_reg [3];
    logic signed [KW-1:0]   p3_kx_reg;
    logic signed [RKW-1:0]  p4_rk_reg [3];
    logic signed [FHW-1:0]  p4_fh_reg [3];
    logic signed [UKW-1:0]  p4_uk_reg [3];
    logic signed [WW-1:0]   p5_w_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= '0;
            p2_reg <= '0;
            p3_reg <= '0;
            p4_reg <= '0;
            p5_reg <= '0;
        end
        else if (en)
        begin
            p1_reg <= '{v: n1_v, zero: n1_zero};
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
            p4_reg <= p3_reg;
            p5_reg <= p4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_kx_reg <= $signed(n1_pay[KW-1:0]);
            p1_ky_reg <= $signed(n1_pay[2*KW-1:KW]);
            for (int i = 0; i < 3; i++)
            begin
                p1_a_reg[i]  <= (2*DB)'(fw[(i+1)%3]) * (2*DB)'(up_c[(i+2)%3]);
                p1_b_reg[i]  <= (2*DB)'(fw[(i+2)%3]) * (2*DB)'(up_c[(i+1)%3]);
                p1_fh_reg[i] <= FHW'(fw[i]) * FHW'(hr_s);
                p1_ut_reg[i] <= UTW'(up_c[i]) * UTW'(tan_s);

                p2_rt_reg[i] <= RTW'(p1_a_reg[i]) - RTW'(p1_b_reg[i]);
                p2_fh_reg[i] <= p1_fh_reg[i];
                p2_uk_reg[i] <= UKW'(p1_ut_reg[i]) * UKW'(p1_ky_reg);

                p3_rtt_reg[i] <= RTTW'(p2_rt_reg[i]) * RTTW'(tan_s);
                p3_fh_reg[i]  <= p2_fh_reg[i];
                p3_uk_reg[i]  <= p2_uk_reg[i];

                p4_rk_reg[i] <= RKW'(p3_rtt_reg[i]) * RKW'(p3_kx_reg);
                p4_fh_reg[i] <= p3_fh_reg[i];
                p4_uk_reg[i] <= p3_uk_reg[i];

                p5_w_reg[i] <= (WW'(p4_fh_reg[i]) <<< (2 * F)) + WW'(p4_rk_reg[i])
                             - (WW'(p4_uk_reg[i]) <<< F);
            end
            p2_kx_reg <= p1_kx_reg;
            p3_kx_reg <= p2_kx_reg;
        end
    end

    // direction normaliser
    logic                 n2_v;
    logic                 n2_zero;
    logic signed [DB-1:0] dir [3];
    logic [0:0]           n2_pay;

    prg_norm #(
        .IW   (WW),
        .FRAC (F),
        .PW   (1)
    ) u_norm_dir (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p5_reg.v),
        .in_vec    (p5_w_reg),
        .in_pay    (p5_reg.zero),
        .out_valid (n2_v),
        .out_zero  (n2_zero),
        .out_vec   (dir),
        .out_pay   (n2_pay)
    );

    // output register
    logic                 m_deg_reg;
    logic signed [DB-1:0] m_dir_reg [3];
    logic                 bad;

    assign bad = n2_zero || n2_pay[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= n2_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_deg_reg <= bad;
            for (int i = 0; i < 3; i++)
            begin
                m_dir_reg[i] <= bad ? '0 : dir[i];
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_deg_reg;
    assign m_tdata  = TW'({m_dir_reg[2], m_dir_reg[1], m_dir_reg[0], eye_reg});

endmodule

`default_nettype wire

FILE: hw/rtl/prg_checker.sv
// port-level checks for the pinhole ray generator, bound to the top level
// uses pinhole_ray_generator_assert.svh
`default_nettype none
`include "pinhole_ray_generator_assert.svh"

module prg_checker #(
    parameter int COORD_BITS = prg_pkg::COORD_BITS_DEF,
    parameter int DIR_BITS   = prg_pkg::DIR_BITS_DEF,
    parameter int TW         = 112
) (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          s_tready,
    input wire logic          m_tvalid,
    input wire logic          m_tready,
    input wire logic [TW-1:0] m_tdata,
    input wire logic          m_tuser
);
    localparam int DLO = 3 * COORD_BITS;
    localparam int DHI = 3 * COORD_BITS + 3 * DIR_BITS - 1;

    logic dir_zero;

    assign dir_zero = (m_tdata[DHI:DLO] == '0);

    `PRG_ASSERT_SAME(a_deg_dir_zero, m_tvalid && m_tuser, dir_zero, "degenerate ray with direction")
    `PRG_ASSERT_SAME(a_unit_nonzero, m_tvalid && !m_tuser, !dir_zero, "unit direction is zero")
    `PRG_ASSERT_SAME(a_ready_empty, !m_tvalid, s_tready, "not ready with empty output")
    `PRG_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind pinhole_ray_generator prg_checker #(
    .COORD_BITS (COORD_BITS),
    .DIR_BITS   (DIR_BITS),
    .TW         (TW)
) u_prg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: dv/tb_pinhole_ray_generator.sv
// self-checking bench for the pinhole ray generator: pixel requests in, rays out
// rays are predicted in exact integer arithmetic and compared field by field
// depends on prg_pkg and the pinhole_ray_generator rtl
`timescale 1ns / 1ps

module tb_pinhole_ray_generator;
    import prg_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int DB = DIR_BITS_DEF;
    localparam int FRAC = DB - 2;
    localparam int TW = ((3 * CB + 3 * DB + 7) / 8) * 8;
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    typedef longint vec3_t [3];
    typedef struct {
        logic [CB-1:0] org [3];
        logic [DB-1:0] dir [3];
        logic          degen;
    } ray_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [23:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [TW-1:0] m_tdata;
    logic m_tuser;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [3*CB-1:0] cfg_data;

    logic [3*CB-1:0] eye_reg;
    logic [3*CB-1:0] focal_reg;
    logic [3*DB-1:0] up_reg;
    logic [15:0] tan_reg;
    logic [12:0] width_reg;
    logic [12:0] height_reg;

    ray_t ray_q [$];
    int mismatches;
    bit calm;

    pinhole_ray_generator dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit unitize(input vec3_t v, output vec3_t u);
        longint unsigned mag [3];
        longint unsigned top;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        top = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (v[i] < 0) ? -v[i] : v[i];
            if (mag[i] > top)
                top = mag[i];
        end
        u = '{0, 0, 0};
        if (top == 0)
            return 1'b0;
        while (top >= (64'd1 << 30))
        begin
            for (int i = 0; i < 3; i++)
                mag[i] >>= 1;
            top >>= 1;
        end
        while (top < (64'd1 << 29))
        begin
            for (int i = 0; i < 3; i++)
                mag[i] <<= 1;
            top <<= 1;
        end
        for (int i = 0; i < 3; i++)
            sum += mag[i] * mag[i];
        len = isqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << FRAC) + (len >> 1)) / len;
            u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic longint clamp_res(logic [12:0] r);
        if (r == 0)
            return 1;
        if (r > MAX_RESOLUTION_DEF)
            return MAX_RESOLUTION_DEF;
        return longint'(r);
    endfunction

    function automatic ray_t trace_ray(logic [11:0] px, logic [11:0] py);
        ray_t r;
        vec3_t eye, gap, up, fw, rt, w, dir;
        longint wr, hr, kx, ky, t;
        bit ok;
        wr = clamp_res(width_reg);
        hr = clamp_res(height_reg);
        kx = 2 * longint'(px) - wr;
        ky = 2 * longint'(py) - hr;
        t = longint'(tan_reg);
        dir = '{0, 0, 0};
        for (int i = 0; i < 3; i++)
        begin
            eye[i] = longint'($signed(eye_reg[CB*i +: CB]));
            gap[i] = longint'($signed(focal_reg[CB*i +: CB])) - eye[i];
            up[i] = longint'($signed(up_reg[DB*i +: DB]));
        end
        ok = unitize(gap, fw);
        if (ok)
        begin
            rt[0] = fw[1] * up[2] - fw[2] * up[1];
            rt[1] = fw[2] * up[0] - fw[0] * up[2];
            rt[2] = fw[0] * up[1] - fw[1] * up[0];
            for (int i = 0; i < 3; i++)
                w[i] = fw[i] * hr * (64'sd1 <<< (2 * FRAC)) + rt[i] * t * kx
                     - up[i] * t * ky * (64'sd1 <<< FRAC);
            ok = unitize(w, dir);
        end
        for (int i = 0; i < 3; i++)
        begin
            r.org[i] = eye[i][CB-1:0];
            r.dir[i] = ok ? dir[i][DB-1:0] : '0;
        end
        r.degen = !ok;
        return r;
    endfunction

    always @(posedge clk)
    begin
        ray_t e;
        bit bad;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (ray_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected ray %h user %b", m_tdata, m_tuser);
            end
            else
            begin
                e = ray_q.pop_front();
                bad = (m_tuser !== e.degen) || (m_tdata[TW-1:3*CB+3*DB] !== '0);
                for (int i = 0; i < 3; i++)
                    bad |= (m_tdata[CB*i +: CB] !== e.org[i])
                         || (m_tdata[3*CB + DB*i +: DB] !== e.dir[i]);
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ray mismatch: exp org %h %h %h dir %h %h %h deg %b, got %h deg %b",
                                 e.org[0], e.org[1], e.org[2], e.dir[0], e.dir[1], e.dir[2],
                                 e.degen, m_tdata, m_tuser);
                end
            end
        end
    end

    // output-side backpressure
    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    end

    task automatic send_pixel(logic [11:0] px, logic [11:0] py);
        s_tvalid <= 1'b1;
        s_tdata <= {py, px};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        ray_q.push_back(trace_ray(px, py));
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (ray_q.size() != 0)
            @(posedge clk);
        repeat (130) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [3*CB-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_EYE:    eye_reg = val;
            REG_FOCAL:  focal_reg = val;
            REG_UP:     up_reg = val[3*DB-1:0];
            REG_TAN:    tan_reg = val[15:0];
            REG_WIDTH:  width_reg = val[12:0];
            REG_HEIGHT: height_reg = val[12:0];
            default: ;
        endcase
    endtask

    function automatic logic [3*CB-1:0] rand_point();
        logic [3*CB-1:0] v;
        v = (3*CB)'({$urandom, $urandom});
        if ($urandom_range(0, 1))
            for (int i = 0; i < 3; i++)
                v[CB*i +: CB] = CB'($signed(v[CB*i +: 12]));
        return v;
    endfunction

    task automatic test_defaults;
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd512, 12'd384);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd1023, 12'd767);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
    endtask

    task automatic test_corner_configs;
        write_reg(REG_WIDTH, 60'd4096);
        write_reg(REG_HEIGHT, 60'd4096);
        write_reg(REG_TAN, 60'hFFFF);
        write_reg(REG_EYE, {20'h80000, 20'h7FFFF, 20'h80000});
        write_reg(REG_FOCAL, {20'h7FFFF, 20'h80000, 20'h7FFFF});
        write_reg(REG_UP, 60'({16'h8000, 16'h7FFF, 16'h8000}));
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        // eye on the focal point
        write_reg(REG_FOCAL, {20'h80000, 20'h7FFFF, 20'h80000});
        send_pixel(12'd7, 12'd9);
        // out-of-range resolution and zero tangent
        write_reg(REG_EYE, 60'd0);
        write_reg(REG_FOCAL, 60'd1024);
        write_reg(REG_WIDTH, 60'd0);
        write_reg(REG_HEIGHT, 60'h1FFF);
        write_reg(REG_TAN, 60'd0);
        send_pixel(12'd100, 12'd3000);
        write_reg(REG_WIDTH, 60'h1FFF);
        write_reg(REG_HEIGHT, 60'd0);
        write_reg(REG_TAN, 60'd16384);
        send_pixel(12'd4095, 12'd1);
        // up along forward, so the right vector vanishes and the sum cancels
        write_reg(REG_UP, 60'd16384);
        write_reg(REG_HEIGHT, 60'd600);
        send_pixel(12'd300, 12'd600);
        send_pixel(12'd300, 12'd0);
        write_reg(REG_UP, 60'd0);
        send_pixel(12'd33, 12'd44);
        // writes to unused indexes are dropped
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        send_pixel(12'd1, 12'd2);
    endtask

    task automatic test_random(int phases, int per_phase);
        logic [11:0] px;
        logic [11:0] py;
        for (int p = 0; p < phases; p++)
        begin
            write_reg(REG_EYE, rand_point());
            write_reg(REG_FOCAL, ($urandom_range(0, 15) == 0) ? eye_reg : rand_point());
            write_reg(REG_UP, ($urandom_range(0, 2) == 0) ? 60'(64'd16384 << (DB * $urandom_range(0, 2)))
                                                      : 60'({$urandom, $urandom}));
            write_reg(REG_TAN, 60'($urandom_range(0, 65535)));
            write_reg(REG_WIDTH, 60'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                              : $urandom_range(1, 4096)));
            write_reg(REG_HEIGHT, 60'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                               : $urandom_range(1, 4096)));
            for (int n = 0; n < per_phase; n++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    px = 12'($urandom);
                    py = 12'($urandom);
                end
                else
                begin
                    px = 12'($urandom_range(0, 32'(clamp_res(width_reg))));
                    py = 12'($urandom_range(0, 32'(clamp_res(height_reg))));
                end
                send_pixel(px, py);
                if (n == per_phase / 2 && p == 0)
                    drain();
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_EYE;
        cfg_data <= '0;
        calm = 1'b0;
        mismatches = 0;
        eye_reg = '0;
        focal_reg = 60'd1024;
        up_reg = 48'(64'd16384 << (2 * DB));
        tan_reg = 16'd16384;
        width_reg = 13'd1024;
        height_reg = 13'd768;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_corner_configs();
        test_random(8, 220);
        calm = 1'b1;
        test_random(1, 160);
        drain();
        if (mismatches == 0 && ray_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
